/* hdl/kmeans_cluster_engine_macros.svh */
// Assertion helpers for the k-means engine.
`ifndef KMEANS_CLUSTER_ENGINE_MACROS_SVH
`define KMEANS_CLUSTER_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define KCE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define KCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define KCE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define KCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* hdl/kce_pkg.sv */
package kce_pkg;

  // parameter defaults
  localparam int KCE_MAX_POINTS   = 256;
  localparam int KCE_MAX_CLUSTERS = 16;
  localparam int KCE_MAX_DIM      = 8;
  localparam int KCE_COORD_WIDTH  = 16;

  // fixed arithmetic widths
  localparam int SQ_W       = 48;            // squared-distance accumulator
  localparam int ROOT_W     = 32;            // isqrt result
  localparam int RAD_W      = 64;            // isqrt radicand
  localparam int REM_W      = ROOT_W + 3;
  localparam int COST_W     = 40;
  localparam int ITER_W     = 8;
  localparam int CFG_DATA_W = 24;

  localparam logic [SQ_W-1:0]   SQ_SAT   = SQ_W'(1) << 47;
  localparam logic [COST_W-1:0] COST_MAX = '1;

  typedef enum logic [2:0] {
    OP_LOAD  = 3'd0,
    OP_RUN   = 3'd1,
    OP_RD_AS = 3'd2,
    OP_RD_CN = 3'd3,
    OP_CLEAR = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FEW  = 2'd1,
    ST_CAP  = 2'd2,
    ST_FULL = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_NUM_CLUSTERS = 2'd0,
    REG_DIMENSION    = 2'd1,
    REG_THRESHOLD    = 2'd2,
    REG_MAX_ITER     = 2'd3
  } cfg_idx_e;

  localparam logic [4:0]            RST_NUM_CLUSTERS = 5'd2;
  localparam logic [3:0]            RST_DIMENSION    = 4'd2;
  localparam logic [CFG_DATA_W-1:0] RST_THRESHOLD    = 24'd1;
  localparam logic [ITER_W-1:0]     RST_MAX_ITER     = 8'd100;

endpackage

/* hdl/kmeans_cluster_engine.sv */
// Lloyd k-means engine over points held in on-chip RAM.
// Command channel: an item is taken when start_i is high and busy_o is low. operation_i
// selects load coordinate, run, read assignment, read centroid coordinate or clear.
// Every command gives one result, shown for one cycle with done_o high; the receiver
// cannot stall it. iteration_count_o and final_cost_o show the last run while idle.
// Latency: load, clear and a run refused for too few points answer the cycle after
// the transfer and keep busy_o low, so one may be issued every cycle. Reads pass the
// registered RAM read and the S_READ state. A run is busy for its whole length: it
//   copies the first K points into the centroids, then per iteration clears the sums,
//   then per point tries each eligible centroid (distance, isqrt, divide, compare) and
//   adds the point to its cluster's sums, then divides each non-empty cluster's sums.
// isqrt and both divisions run bit-serially in one shared shift/subtract sequencer,
// which sets the run time. Config writes use the cfg_* valid/ready channel and are
// taken only while idle. Reset clears the control state and loads the default
// registers; the point, centroid and assignment RAMs hold garbage until written.
`include "kmeans_cluster_engine_macros.svh"

module kmeans_cluster_engine
  import kce_pkg::*;
#(
  parameter int MAX_POINTS   = KCE_MAX_POINTS,
  parameter int MAX_CLUSTERS = KCE_MAX_CLUSTERS,
  parameter int MAX_DIM      = KCE_MAX_DIM,
  parameter int COORD_WIDTH  = KCE_COORD_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [2:0]                    operation_i,
  input  logic signed [COORD_WIDTH-1:0] value_i,
  input  logic [7:0]                    point_index_i,
  input  logic [3:0]                    cluster_index_i,
  input  logic [2:0]                    coord_index_i,
  output logic                          done_o,
  output logic [1:0]                    status_o,
  output logic [3:0]                    cluster_id_o,
  output logic signed [COORD_WIDTH-1:0] coord_value_o,
  output logic [ITER_W-1:0]             iteration_count_o,
  output logic [COST_W-1:0]             final_cost_o
);

  localparam int PT_W     = $clog2(MAX_POINTS);
  localparam int PCNT_W   = $clog2(MAX_POINTS + 1);
  localparam int CL_W     = $clog2(MAX_CLUSTERS);
  localparam int K_W      = $clog2(MAX_CLUSTERS + 1);
  localparam int DIM_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int EDIM_W   = $clog2(MAX_DIM + 1);
  localparam int NZ_W     = EDIM_W;
  localparam int DIVR_W   = NZ_W + 1;
  localparam int SUM_W    = COORD_WIDTH + PT_W;
  localparam int DVS_W    = (PCNT_W > DIVR_W) ? PCNT_W : DIVR_W;
  localparam int DVD_W    = (SUM_W > ROOT_W) ? SUM_W : ROOT_W;
  localparam int STEP_W   = $clog2(DVD_W + 1);
  localparam int PD_W     = COORD_WIDTH + 1;
  localparam int PROD_W   = 2 * PD_W;
  localparam int SW       = (PROD_W > SQ_W) ? PROD_W + 1 : SQ_W + 1;
  localparam int PS_AW    = PT_W + DIM_W;
  localparam int CS_AW    = CL_W + DIM_W;
  localparam int PS_DEPTH = MAX_POINTS * (2 ** DIM_W);
  localparam int CS_DEPTH = MAX_CLUSTERS * (2 ** DIM_W);

  typedef enum logic [21:0] {
    S_IDLE     = 22'h000001,
    S_READ     = 22'h000002,
    S_INIT_RD  = 22'h000004,
    S_INIT_WR  = 22'h000008,
    S_CLR      = 22'h000010,
    S_PT_START = 22'h000020,
    S_CAND     = 22'h000040,
    S_DIST_RD  = 22'h000080,
    S_DIST_MUL = 22'h000100,
    S_DIST_ACC = 22'h000200,
    S_SQRT     = 22'h000400,
    S_DIV      = 22'h000800,
    S_CMP      = 22'h001000,
    S_PT_DONE  = 22'h002000,
    S_ACC_RD   = 22'h004000,
    S_ACC_WR   = 22'h008000,
    S_UPD_CHK  = 22'h010000,
    S_UPD_RD   = 22'h020000,
    S_UPD_LD   = 22'h040000,
    S_UPD_WR   = 22'h080000,
    S_CONV     = 22'h100000,
    S_FIN      = 22'h200000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [4:0]            cfg_k_q;
  logic [3:0]            cfg_dim_q;
  logic [CFG_DATA_W-1:0] cfg_thr_q;
  logic [ITER_W-1:0]     cfg_cap_q;

  // control and run state
  logic [PCNT_W-1:0] points_q, points_d;
  logic [DIM_W-1:0]  cpos_q, cpos_d;
  logic [NZ_W-1:0]   nz_acc_q, nz_acc_d;
  logic [COST_W-1:0] cost_q, cost_d, prev_q, prev_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic [K_W-1:0]    c_q, c_d;
  logic [EDIM_W-1:0] d_q, d_d;
  logic [PCNT_W-1:0] p_q, p_d;
  logic [CL_W-1:0]   best_q, best_d;
  logic [ROOT_W-1:0] bestd_q, bestd_d;
  logic              found_q, found_d;
  logic [DIVR_W-1:0] div_q, div_d;
  logic [SQ_W-1:0]   acc_q, acc_d;
  logic [PROD_W-1:0] sq_q, sq_d;
  logic [RAD_W-1:0]  rad_q, rad_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [DVD_W-1:0]  dvd_q, dvd_d;
  logic [DVS_W-1:0]  dvs_q, dvs_d, drem_q, drem_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              upd_q, upd_d, neg_q, neg_d;
  logic [NZ_W-1:0]   nzc_q, nzc_d;
  logic [CS_AW-1:0]  clr_q, clr_d;
  logic [PCNT_W-1:0] mc_q [MAX_CLUSTERS];
  logic [PCNT_W-1:0] mc_d [MAX_CLUSTERS];
  logic [NZ_W-1:0]   cnz_q [MAX_CLUSTERS];
  logic [NZ_W-1:0]   cnz_d [MAX_CLUSTERS];
  status_e           run_st_q, run_st_d;
  logic              rd_as_q, rd_as_d, rd_ok_q, rd_ok_d;

  // result registers
  logic                   done_q, done_d;
  status_e                res_st_q, res_st_d;
  logic [3:0]             cid_q, cid_d;
  logic [COORD_WIDTH-1:0] cval_q, cval_d;

  // RAM ports
  logic                   ps_we;
  logic [PS_AW-1:0]       ps_waddr, ps_raddr;
  logic [COORD_WIDTH-1:0] ps_rdata;
  logic                   pnz_we;
  logic [PT_W-1:0]        pnz_waddr, pnz_raddr;
  logic [NZ_W-1:0]        pnz_wdata, pnz_rdata;
  logic                   cn_we;
  logic [CS_AW-1:0]       cn_waddr, cn_raddr;
  logic [COORD_WIDTH-1:0] cn_wdata, cn_rdata;
  logic                   as_we;
  logic [CL_W-1:0]        as_rdata;
  logic                   sm_we;
  logic [CS_AW-1:0]       sm_waddr, sm_raddr;
  logic [SUM_W-1:0]       sm_wdata, sm_rdata;

  logic [K_W-1:0]    eff_k;
  logic [EDIM_W-1:0] eff_dim;
  logic [ITER_W-1:0] cap;
  logic              accept;
  logic [DIM_W-1:0]  ld_pos;
  logic              ld_pos_last;
  logic              v_pos;
  logic [NZ_W-1:0]   ld_nz;
  logic              d_last, c_last, p_last;
  logic [CL_W-1:0]   mc_idx;
  logic [PCNT_W-1:0] mc_sel;
  logic [DIVR_W-1:0] cand_div;
  logic [PD_W-1:0]   diff, diff_mag;
  logic [SW-1:0]     sq_sum;
  logic [REM_W-1:0]  sq_rem_sh, sq_trial;
  logic [DVS_W:0]    dv_sh;
  logic [ROOT_W-1:0] dd;
  logic [COST_W:0]   cost_add;
  logic [COST_W-1:0] cost_diff;
  logic [SUM_W-1:0]  pt_ext, sum_mag;
  logic [COORD_WIDTH-1:0] mean;
  logic [ITER_W-1:0] iter_inc;

  assign busy_o            = (state_q != S_IDLE);
  assign cfg_ready_o       = ~busy_o;
  assign accept            = start_i && !busy_o;
  assign done_o            = done_q;
  assign status_o          = res_st_q;
  assign cluster_id_o      = cid_q;
  assign coord_value_o     = cval_q;
  assign iteration_count_o = iter_q;
  assign final_cost_o      = cost_q;

  always_comb begin
    if (cfg_k_q == '0) begin
      eff_k = K_W'(1);
    end else if (int'(cfg_k_q) > MAX_CLUSTERS) begin
      eff_k = K_W'(MAX_CLUSTERS);
    end else begin
      eff_k = K_W'(cfg_k_q);
    end
    if (cfg_dim_q == '0) begin
      eff_dim = EDIM_W'(1);
    end else if (int'(cfg_dim_q) > MAX_DIM) begin
      eff_dim = EDIM_W'(MAX_DIM);
    end else begin
      eff_dim = EDIM_W'(cfg_dim_q);
    end
    cap = (cfg_cap_q == '0) ? ITER_W'(1) : cfg_cap_q;
  end

  // load path
  assign ld_pos      = (int'(cpos_q) >= MAX_DIM) ? DIM_W'(MAX_DIM - 1) : cpos_q;
  assign ld_pos_last = (int'(ld_pos) + 1 >= int'(eff_dim));
  assign v_pos       = !value_i[COORD_WIDTH-1] && (|value_i);
  assign ld_nz       = (ld_pos == '0) ? NZ_W'(v_pos) : nz_acc_q + NZ_W'(v_pos);

  assign d_last = (int'(d_q) + 1 >= int'(eff_dim));
  assign c_last = (int'(c_q) + 1 >= int'(eff_k));
  assign p_last = (int'(p_q) + 1 >= int'(points_q));

  assign mc_idx   = (state_q == S_PT_DONE) ? best_q : c_q[CL_W-1:0];
  assign mc_sel   = mc_q[mc_idx];
  assign cand_div = DIVR_W'(pnz_rdata) + DIVR_W'(cnz_q[c_q[CL_W-1:0]]);

  // squared difference, one coordinate per pass
  assign diff     = PD_W'(signed'(cn_rdata)) - PD_W'(signed'(ps_rdata));
  assign diff_mag = diff[PD_W-1] ? (~diff + PD_W'(1)) : diff;
  assign sq_sum   = SW'(acc_q) + SW'(sq_q);

  // shared shift/subtract step: isqrt digit and restoring divide bit
  assign sq_rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign sq_trial  = REM_W'({root_q, 2'b01});
  assign dv_sh     = {drem_q, dvd_q[DVD_W-1]};
  assign dd        = dvd_q[ROOT_W-1:0];

  assign cost_add  = {1'b0, cost_q} + (COST_W + 1)'(bestd_q);
  assign cost_diff = (cost_q >= prev_q) ? (cost_q - prev_q) : (prev_q - cost_q);
  assign pt_ext    = {{(SUM_W - COORD_WIDTH){ps_rdata[COORD_WIDTH-1]}}, ps_rdata};
  assign sum_mag   = sm_rdata[SUM_W-1] ? (~sm_rdata + SUM_W'(1)) : sm_rdata;
  assign mean      = neg_q ? (~dvd_q[COORD_WIDTH-1:0] + COORD_WIDTH'(1))
                           : dvd_q[COORD_WIDTH-1:0];
  assign iter_inc  = iter_q + ITER_W'(1);

  // RAM addressing
  always_comb begin
    ps_we     = accept && (operation_i == OP_LOAD) && (int'(points_q) < MAX_POINTS);
    ps_waddr  = {points_q[PT_W-1:0], ld_pos};
    ps_raddr  = (state_q == S_INIT_RD) ? {PT_W'(c_q), d_q[DIM_W-1:0]}
                                       : {p_q[PT_W-1:0], d_q[DIM_W-1:0]};
    pnz_we    = ps_we;
    pnz_waddr = points_q[PT_W-1:0];
    pnz_wdata = ld_nz;
    pnz_raddr = (state_q == S_INIT_RD) ? PT_W'(c_q) : p_q[PT_W-1:0];
    cn_we     = (state_q == S_INIT_WR) || (state_q == S_UPD_WR);
    cn_waddr  = {c_q[CL_W-1:0], d_q[DIM_W-1:0]};
    cn_wdata  = (state_q == S_INIT_WR) ? ps_rdata : mean;
    cn_raddr  = (state_q == S_IDLE) ? {CL_W'(cluster_index_i), DIM_W'(coord_index_i)}
                                    : {c_q[CL_W-1:0], d_q[DIM_W-1:0]};
    as_we     = (state_q == S_PT_DONE);
    sm_we     = (state_q == S_CLR) || (state_q == S_ACC_WR);
    sm_waddr  = (state_q == S_CLR) ? clr_q : {best_q, d_q[DIM_W-1:0]};
    sm_wdata  = (state_q == S_CLR) ? '0 : (sm_rdata + pt_ext);
    sm_raddr  = (state_q == S_ACC_RD) ? {best_q, d_q[DIM_W-1:0]}
                                      : {c_q[CL_W-1:0], d_q[DIM_W-1:0]};
  end

  kce_ram #(.WIDTH(COORD_WIDTH), .DEPTH(PS_DEPTH)) u_point_ram (
    .clk_i, .we_i(ps_we), .waddr_i(ps_waddr), .wdata_i(value_i),
    .raddr_i(ps_raddr), .rdata_o(ps_rdata)
  );

  kce_ram #(.WIDTH(NZ_W), .DEPTH(MAX_POINTS)) u_point_nz_ram (
    .clk_i, .we_i(pnz_we), .waddr_i(pnz_waddr), .wdata_i(pnz_wdata),
    .raddr_i(pnz_raddr), .rdata_o(pnz_rdata)
  );

  kce_ram #(.WIDTH(COORD_WIDTH), .DEPTH(CS_DEPTH)) u_centroid_ram (
    .clk_i, .we_i(cn_we), .waddr_i(cn_waddr), .wdata_i(cn_wdata),
    .raddr_i(cn_raddr), .rdata_o(cn_rdata)
  );

  kce_ram #(.WIDTH(CL_W), .DEPTH(MAX_POINTS)) u_assign_ram (
    .clk_i, .we_i(as_we), .waddr_i(p_q[PT_W-1:0]), .wdata_i(best_q),
    .raddr_i(PT_W'(point_index_i)), .rdata_o(as_rdata)
  );

  kce_ram #(.WIDTH(SUM_W), .DEPTH(CS_DEPTH)) u_sum_ram (
    .clk_i, .we_i(sm_we), .waddr_i(sm_waddr), .wdata_i(sm_wdata),
    .raddr_i(sm_raddr), .rdata_o(sm_rdata)
  );

  // sequencer
  always_comb begin
    state_d  = state_q;
    points_d = points_q;
    cpos_d   = cpos_q;
    nz_acc_d = nz_acc_q;
    cost_d   = cost_q;
    prev_d   = prev_q;
    iter_d   = iter_q;
    c_d      = c_q;
    d_d      = d_q;
    p_d      = p_q;
    best_d   = best_q;
    bestd_d  = bestd_q;
    found_d  = found_q;
    div_d    = div_q;
    acc_d    = acc_q;
    sq_d     = sq_q;
    rad_d    = rad_q;
    root_d   = root_q;
    rem_d    = rem_q;
    dvd_d    = dvd_q;
    dvs_d    = dvs_q;
    drem_d   = drem_q;
    step_d   = step_q;
    upd_d    = upd_q;
    neg_d    = neg_q;
    nzc_d    = nzc_q;
    clr_d    = clr_q;
    mc_d     = mc_q;
    cnz_d    = cnz_q;
    run_st_d = run_st_q;
    rd_as_d  = rd_as_q;
    rd_ok_d  = rd_ok_q;
    done_d   = 1'b0;
    res_st_d = res_st_q;
    cid_d    = cid_q;
    cval_d   = cval_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_st_d = ST_OK;
          cid_d    = '0;
          cval_d   = '0;
          case (operation_i)
            OP_LOAD: begin
              done_d = 1'b1;
              if (int'(points_q) >= MAX_POINTS) begin
                res_st_d = ST_FULL;
              end else begin
                nz_acc_d = ld_nz;
                if (ld_pos_last) begin
                  cpos_d   = '0;
                  points_d = points_q + PCNT_W'(1);
                end else begin
                  cpos_d = ld_pos + DIM_W'(1);
                end
              end
            end
            OP_RUN: begin
              if (int'(points_q) < int'(eff_k)) begin
                done_d   = 1'b1;
                res_st_d = ST_FEW;
              end else begin
                prev_d  = '0;
                iter_d  = '0;
                c_d     = '0;
                d_d     = '0;
                state_d = S_INIT_RD;
              end
            end
            OP_RD_AS: begin
              rd_as_d = 1'b1;
              rd_ok_d = (int'(point_index_i) < MAX_POINTS);
              state_d = S_READ;
            end
            OP_RD_CN: begin
              rd_as_d = 1'b0;
              rd_ok_d = (int'(cluster_index_i) < MAX_CLUSTERS) &&
                        (int'(coord_index_i) < MAX_DIM);
              state_d = S_READ;
            end
            OP_CLEAR: begin
              done_d   = 1'b1;
              points_d = '0;
              cpos_d   = '0;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      S_READ: begin
        done_d = 1'b1;
        if (rd_ok_q && rd_as_q) begin
          cid_d = 4'(as_rdata);
        end else if (rd_ok_q) begin
          cval_d = cn_rdata;
        end
        state_d = S_IDLE;
      end

      S_INIT_RD: begin
        state_d = S_INIT_WR;
      end

      S_INIT_WR: begin
        cnz_d[c_q[CL_W-1:0]] = pnz_rdata;
        if (!d_last) begin
          d_d     = d_q + EDIM_W'(1);
          state_d = S_INIT_RD;
        end else if (!c_last) begin
          d_d     = '0;
          c_d     = c_q + K_W'(1);
          state_d = S_INIT_RD;
        end else begin
          cost_d  = '0;
          mc_d    = '{default: '0};
          clr_d   = '0;
          state_d = S_CLR;
        end
      end

      // wipe the per-cluster coordinate sums
      S_CLR: begin
        clr_d = clr_q + CS_AW'(1);
        if (int'(clr_q) == CS_DEPTH - 1) begin
          p_d     = '0;
          state_d = S_PT_START;
        end
      end

      S_PT_START: begin
        c_d     = '0;
        found_d = 1'b0;
        best_d  = '0;
        state_d = S_CAND;
      end

      S_CAND: begin
        if (cand_div == '0) begin
          // no divisor: this centroid cannot win
          if (c_last) begin
            state_d = S_PT_DONE;
          end else begin
            c_d = c_q + K_W'(1);
          end
        end else begin
          div_d   = cand_div;
          d_d     = '0;
          acc_d   = '0;
          state_d = S_DIST_RD;
        end
      end

      S_DIST_RD: begin
        state_d = S_DIST_MUL;
      end

      S_DIST_MUL: begin
        sq_d    = PROD_W'(diff_mag) * PROD_W'(diff_mag);
        state_d = S_DIST_ACC;
      end

      S_DIST_ACC: begin
        if (sq_sum > SW'(SQ_SAT)) begin
          acc_d = SQ_SAT;
        end else begin
          acc_d = sq_sum[SQ_W-1:0];
        end
        if (d_last) begin
          rad_d   = {acc_d, 16'h0000};
          root_d  = '0;
          rem_d   = '0;
          step_d  = '0;
          state_d = S_SQRT;
        end else begin
          d_d     = d_q + EDIM_W'(1);
          state_d = S_DIST_RD;
        end
      end

      S_SQRT: begin
        rad_d = {rad_q[RAD_W-3:0], 2'b00};
        if (sq_rem_sh >= sq_trial) begin
          rem_d  = sq_rem_sh - sq_trial;
          root_d = {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          rem_d  = sq_rem_sh;
          root_d = {root_q[ROOT_W-2:0], 1'b0};
        end
        step_d = step_q + STEP_W'(1);
        if (int'(step_q) == ROOT_W - 1) begin
          dvd_d   = DVD_W'(root_d);
          dvs_d   = DVS_W'(div_q);
          drem_d  = '0;
          step_d  = '0;
          upd_d   = 1'b0;
          state_d = S_DIV;
        end
      end

      S_DIV: begin
        if (dv_sh >= {1'b0, dvs_q}) begin
          drem_d = DVS_W'(dv_sh - {1'b0, dvs_q});
          dvd_d  = {dvd_q[DVD_W-2:0], 1'b1};
        end else begin
          drem_d = dv_sh[DVS_W-1:0];
          dvd_d  = {dvd_q[DVD_W-2:0], 1'b0};
        end
        step_d = step_q + STEP_W'(1);
        if (int'(step_q) == DVD_W - 1) begin
          state_d = upd_q ? S_UPD_WR : S_CMP;
        end
      end

      S_CMP: begin
        // strict compare keeps the lower cluster on ties
        if (!found_q || (dd < bestd_q)) begin
          found_d = 1'b1;
          bestd_d = dd;
          best_d  = c_q[CL_W-1:0];
        end
        if (c_last) begin
          state_d = S_PT_DONE;
        end else begin
          c_d     = c_q + K_W'(1);
          state_d = S_CAND;
        end
      end

      S_PT_DONE: begin
        if (!found_q || cost_add[COST_W]) begin
          cost_d = COST_MAX;
        end else begin
          cost_d = cost_add[COST_W-1:0];
        end
        mc_d[best_q] = mc_sel + PCNT_W'(1);
        d_d          = '0;
        state_d      = S_ACC_RD;
      end

      S_ACC_RD: begin
        state_d = S_ACC_WR;
      end

      S_ACC_WR: begin
        if (!d_last) begin
          d_d     = d_q + EDIM_W'(1);
          state_d = S_ACC_RD;
        end else if (!p_last) begin
          p_d     = p_q + PCNT_W'(1);
          state_d = S_PT_START;
        end else begin
          c_d     = '0;
          state_d = S_UPD_CHK;
        end
      end

      S_UPD_CHK: begin
        if (int'(c_q) >= int'(eff_k)) begin
          state_d = S_CONV;
        end else if (mc_sel == '0) begin
          c_d = c_q + K_W'(1);
        end else begin
          d_d     = '0;
          nzc_d   = '0;
          state_d = S_UPD_RD;
        end
      end

      S_UPD_RD: begin
        state_d = S_UPD_LD;
      end

      S_UPD_LD: begin
        neg_d   = sm_rdata[SUM_W-1];
        dvd_d   = DVD_W'(sum_mag);
        dvs_d   = DVS_W'(mc_sel);
        drem_d  = '0;
        step_d  = '0;
        upd_d   = 1'b1;
        state_d = S_DIV;
      end

      S_UPD_WR: begin
        nzc_d = nzc_q + NZ_W'(dvd_q != '0);
        cnz_d[c_q[CL_W-1:0]] = nzc_d;
        if (d_last) begin
          c_d     = c_q + K_W'(1);
          state_d = S_UPD_CHK;
        end else begin
          d_d     = d_q + EDIM_W'(1);
          state_d = S_UPD_RD;
        end
      end

      S_CONV: begin
        iter_d = iter_inc;
        if (cost_diff < COST_W'(cfg_thr_q)) begin
          run_st_d = ST_OK;
          state_d  = S_FIN;
        end else begin
          prev_d = cost_q;
          if (iter_inc >= cap) begin
            run_st_d = ST_CAP;
            state_d  = S_FIN;
          end else begin
            cost_d  = '0;
            mc_d    = '{default: '0};
            clr_d   = '0;
            state_d = S_CLR;
          end
        end
      end

      S_FIN: begin
        done_d   = 1'b1;
        res_st_d = run_st_q;
        cid_d    = '0;
        cval_d   = '0;
        state_d  = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cfg_k_q   <= RST_NUM_CLUSTERS;
      cfg_dim_q <= RST_DIMENSION;
      cfg_thr_q <= RST_THRESHOLD;
      cfg_cap_q <= RST_MAX_ITER;
      points_q  <= '0;
      cpos_q    <= '0;
      cost_q    <= '0;
      prev_q    <= '0;
      iter_q    <= '0;
      mc_q      <= '{default: '0};
      done_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      points_q <= points_d;
      cpos_q   <= cpos_d;
      cost_q   <= cost_d;
      prev_q   <= prev_d;
      iter_q   <= iter_d;
      mc_q     <= mc_d;
      done_q   <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_NUM_CLUSTERS: cfg_k_q   <= cfg_data_i[4:0];
          REG_DIMENSION:    cfg_dim_q <= cfg_data_i[3:0];
          REG_THRESHOLD:    cfg_thr_q <= cfg_data_i;
          REG_MAX_ITER:     cfg_cap_q <= cfg_data_i[ITER_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    nz_acc_q <= nz_acc_d;
    c_q      <= c_d;
    d_q      <= d_d;
    p_q      <= p_d;
    best_q   <= best_d;
    bestd_q  <= bestd_d;
    found_q  <= found_d;
    div_q    <= div_d;
    acc_q    <= acc_d;
    sq_q     <= sq_d;
    rad_q    <= rad_d;
    root_q   <= root_d;
    rem_q    <= rem_d;
    dvd_q    <= dvd_d;
    dvs_q    <= dvs_d;
    drem_q   <= drem_d;
    step_q   <= step_d;
    upd_q    <= upd_d;
    neg_q    <= neg_d;
    nzc_q    <= nzc_d;
    clr_q    <= clr_d;
    cnz_q    <= cnz_d;
    run_st_q <= run_st_d;
    rd_as_q  <= rd_as_d;
    rd_ok_q  <= rd_ok_d;
    res_st_q <= res_st_d;
    cid_q    <= cid_d;
    cval_q   <= cval_d;
  end

  `KCE_ASSERT_NOW(a_done_idle, clk_i, rst_ni, done_o, !busy_o, "result while busy")
  `KCE_ASSERT_NEXT(a_load_answers, clk_i, rst_ni, accept && (operation_i == OP_LOAD), done_o && !busy_o, "load not answered next cycle")
  `KCE_ASSERT_NEXT(a_iter_step, clk_i, rst_ni, state_q == S_CONV, iter_q == $past(iter_q) + ITER_W'(1), "iteration count not advanced")
  `KCE_ASSERT_NOW(a_points_bound, clk_i, rst_ni, 1'b1, int'(points_q) <= MAX_POINTS, "point count past store size")

endmodule

/* hdl/kce_ram.sv */
module kce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* bench/tb_kmeans_cluster_engine.sv */
`timescale 1ns / 1ps

module tb_kmeans_cluster_engine;
  import kce_pkg::*;

  typedef struct packed {
    logic [1:0]         status;
    logic [3:0]         cluster_id;
    logic [15:0]        coord_value;
    logic [ITER_W-1:0]  iteration_count;
    logic [COST_W-1:0]  final_cost;
  } kce_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [1:0]            cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  start_i = 1'b0;
  logic                  busy_o;
  logic [2:0]            operation_i = '0;
  logic signed [15:0]    value_i = '0;
  logic [7:0]            point_index_i = '0;
  logic [3:0]            cluster_index_i = '0;
  logic [2:0]            coord_index_i = '0;
  logic                  done_o;
  logic [1:0]            status_o;
  logic [3:0]            cluster_id_o;
  logic signed [15:0]    coord_value_o;
  logic [ITER_W-1:0]     iteration_count_o;
  logic [COST_W-1:0]     final_cost_o;

  kmeans_cluster_engine dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the engine
  logic [4:0]            k_reg;
  logic [3:0]            dim_reg;
  logic [23:0]           thr_reg;
  logic [7:0]            cap_reg;
  int                    pts [2048];
  bit                    pts_wr [2048];
  int                    pnz [256];
  int                    cen [128];
  bit                    cen_wr [128];
  int                    cnz [16];
  int                    asg [256];
  bit                    asg_wr [256];
  int                    points_loaded, coord_pos;
  longint unsigned       cost_acc, prev_cost;
  int                    iters;

  kce_result_t           expected_q[$];
  int                    fails = 0;
  int                    n_items = 0;
  bit                    quiet = 1'b0;

  function automatic int eff_k();
    if (k_reg == 0) return 1;
    return (k_reg > 16) ? 16 : int'(k_reg);
  endfunction

  function automatic int eff_dim();
    if (dim_reg == 0) return 1;
    return (dim_reg > 8) ? 8 : int'(dim_reg);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned norm_dist(int p, int c, int dim);
    longint unsigned s, m;
    longint          diff;
    s = 0;
    for (int d = 0; d < dim; d++) begin
      diff = longint'(cen[c*8+d]) - longint'(pts[p*8+d]);
      m = (diff < 0) ? -diff : diff;
      s += m * m;
      if (s > (64'd1 << 47)) s = 64'd1 << 47;
    end
    return int_sqrt(s << 16);
  endfunction

  function automatic logic [1:0] lloyd_run();
    int              k, dim, cap, best, dv;
    bit              found;
    longint unsigned bestd, dd, delta;
    longint          sums [128];
    int              members [16];
    longint          mean;
    int              nz;
    k = eff_k();
    dim = eff_dim();
    cap = (cap_reg != 0) ? int'(cap_reg) : 1;
    if (points_loaded < k) return ST_FEW;
    for (int c = 0; c < k; c++) begin
      for (int d = 0; d < dim; d++) begin
        cen[c*8+d] = pts[c*8+d];
        cen_wr[c*8+d] = 1'b1;
      end
      cnz[c] = pnz[c];
    end
    prev_cost = 0;
    iters = 0;
    forever begin
      cost_acc = 0;
      foreach (sums[i]) sums[i] = 0;
      foreach (members[i]) members[i] = 0;
      for (int p = 0; p < points_loaded; p++) begin
        best = 0;
        bestd = 0;
        found = 1'b0;
        for (int c = 0; c < k; c++) begin
          dv = pnz[p] + cnz[c];
          if (dv == 0) continue;
          dd = norm_dist(p, c, dim) / longint'(dv);
          if (!found || dd < bestd) begin
            found = 1'b1;
            bestd = dd;
            best = c;
          end
        end
        if (!found) begin
          cost_acc = COST_MAX;
        end else begin
          cost_acc += bestd;
          if (cost_acc > COST_MAX) cost_acc = COST_MAX;
        end
        asg[p] = best;
        asg_wr[p] = 1'b1;
        members[best]++;
        for (int d = 0; d < dim; d++) sums[best*8+d] += pts[p*8+d];
      end
      for (int c = 0; c < k; c++) begin
        if (members[c] == 0) continue;
        nz = 0;
        for (int d = 0; d < dim; d++) begin
          mean = sums[c*8+d] / longint'(members[c]);
          cen[c*8+d] = int'(mean);
          if (mean != 0) nz++;
        end
        cnz[c] = nz;
      end
      iters++;
      delta = (cost_acc > prev_cost) ? cost_acc - prev_cost : prev_cost - cost_acc;
      if (delta < thr_reg) return ST_OK;
      prev_cost = cost_acc;
      if (iters >= cap) return ST_CAP;
    end
  endfunction

  function automatic kce_result_t predict_command(logic [2:0] op, logic [15:0] val,
                                                  logic [7:0] pidx, logic [3:0] cidx,
                                                  logic [2:0] didx);
    kce_result_t r;
    int          v, pos;
    r = '0;
    case (op)
      OP_LOAD: begin
        if (points_loaded >= 256) begin
          r.status = ST_FULL;
        end else begin
          v = int'($signed(val));
          pos = (coord_pos < 8) ? coord_pos : 7;
          pts[points_loaded*8+pos] = v;
          pts_wr[points_loaded*8+pos] = 1'b1;
          if (pos == 0) pnz[points_loaded] = 0;
          if (v > 0) pnz[points_loaded]++;
          coord_pos = pos + 1;
          if (coord_pos >= eff_dim()) begin
            coord_pos = 0;
            points_loaded++;
          end
        end
      end
      OP_RUN:   r.status = lloyd_run();
      OP_RD_AS: r.cluster_id = asg[pidx][3:0];
      OP_RD_CN: r.coord_value = cen[cidx*8+didx][15:0];
      OP_CLEAR: begin
        points_loaded = 0;
        coord_pos = 0;
      end
      default: ;
    endcase
    r.iteration_count = iters[7:0];
    r.final_cost = cost_acc[COST_W-1:0];
    return r;
  endfunction

  // all tasks below start and end right after a rising edge
  task automatic idle_burst();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  task automatic send_cmd(logic [2:0] op, logic [15:0] val, logic [7:0] pidx = 0,
                          logic [3:0] cidx = 0, logic [2:0] didx = 0);
    idle_burst();
    start_i <= 1'b1;
    operation_i <= op;
    value_i <= val;
    point_index_i <= pidx;
    cluster_index_i <= cidx;
    coord_index_i <= didx;
    do @(posedge clk_i); while (busy_o);
    expected_q.push_back(predict_command(op, val, pidx, cidx, didx));
    n_items++;
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [23:0] data);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_NUM_CLUSTERS: k_reg = data[4:0];
      REG_DIMENSION:    dim_reg = data[3:0];
      REG_THRESHOLD:    thr_reg = data;
      REG_MAX_ITER:     cap_reg = data[7:0];
      default: ;
    endcase
  endtask

  task automatic set_all(int k, int dim, int thr, int cap);
    write_reg(REG_NUM_CLUSTERS, k);
    write_reg(REG_DIMENSION, dim);
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_MAX_ITER, cap);
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3, 4:    return $urandom_range(0, 65535);
      default: return 16'($signed($urandom_range(0, 1023)) - 512);
    endcase
  endfunction

  function automatic bit run_is_safe();
    if (points_loaded < eff_k()) return 1'b1;
    for (int p = 0; p < points_loaded; p++)
      for (int d = 0; d < eff_dim(); d++)
        if (!pts_wr[p*8+d]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic read_back(int n);
    int p, c, d;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 255);
      c = $urandom_range(0, 15);
      d = $urandom_range(0, 7);
      if (asg_wr[p] && $urandom_range(0, 1)) send_cmd(OP_RD_AS, $urandom, p);
      else if (cen_wr[c*8+d]) send_cmd(OP_RD_CN, $urandom, $urandom, c, d);
    end
  endtask

  // loads, run, reads and unknown operation codes
  task automatic test_basic_run();
    set_all(2, 2, 1, 100);
    send_cmd(OP_LOAD, 16'h0100);
    send_cmd(OP_LOAD, 16'h0100);
    send_cmd(OP_RUN, 0);                   // one point, two clusters: too few
    send_cmd(OP_LOAD, 16'h7fff);
    send_cmd(OP_LOAD, 16'h8000);
    send_cmd(OP_LOAD, 16'h0180);
    send_cmd(OP_LOAD, 16'h0080);
    send_cmd(OP_LOAD, 16'h7f00);
    send_cmd(OP_LOAD, 16'h0000);
    send_cmd(OP_LOAD, 16'h0001);           // partial point, left out of the run
    send_cmd(OP_RUN, 0);
    for (int p = 0; p < 4; p++) send_cmd(OP_RD_AS, 0, p);
    for (int c = 0; c < 2; c++)
      for (int d = 0; d < 2; d++) send_cmd(OP_RD_CN, 0, 0, c, d);
    send_cmd(3'd5, 16'hffff, 8'hff, 4'hf, 3'h7);
    send_cmd(3'd7, 0);
  endtask

  // no positive coordinates anywhere: every divisor is zero, cost saturates
  task automatic test_zero_divisor();
    set_all(2, 2, 24'hffffff, 1);
    send_cmd(OP_CLEAR, 0);
    for (int i = 0; i < 6; i++) send_cmd(OP_LOAD, (i % 2) ? 16'h0000 : 16'hff00);
    send_cmd(OP_RUN, 0);
    for (int p = 0; p < 3; p++) send_cmd(OP_RD_AS, 0, p);
  endtask

  // fill the point store, then overflow it; run a cheap pass over all of it
  task automatic test_store_full();
    set_all(1, 1, 24'hffffff, 0);
    send_cmd(OP_CLEAR, 0);
    for (int i = 0; i < 259; i++) send_cmd(OP_LOAD, rand_coord());
    send_cmd(OP_RUN, 0);
    send_cmd(OP_RD_AS, 0, 255);
    send_cmd(OP_RD_CN, 0, 0, 0, 0);
    send_cmd(OP_CLEAR, 0);
  endtask

  // largest K and dimension, out-of-range register values, zero threshold
  task automatic test_register_extremes();
    set_all(16, 8, 0, 2);
    send_cmd(OP_CLEAR, 0);
    for (int i = 0; i < 18 * 8; i++) send_cmd(OP_LOAD, rand_coord());
    send_cmd(OP_RUN, 0);
    read_back(10);
    set_all(31, 15, 0, 1);
    send_cmd(OP_RUN, 0);
    set_all(0, 0, 24'hffffff, 255);
    send_cmd(OP_CLEAR, 0);
    for (int i = 0; i < 5; i++) send_cmd(OP_LOAD, rand_coord());
    send_cmd(OP_RUN, 0);
    read_back(4);
  endtask

  task automatic test_random_runs();
    int n_pts, thr, cap;
    while (n_items < 1600) begin
      if (n_items > 1400) quiet = 1'b1;
      if ($urandom_range(0, 2) == 0 || points_loaded > 40) begin
        write_reg(REG_NUM_CLUSTERS,
                  ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 4));
        write_reg(REG_DIMENSION,
                  ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4));
        case ($urandom_range(0, 3))
          0:       thr = 0;
          1:       thr = 24'hffffff;
          default: thr = $urandom_range(1, 200000);
        endcase
        cap = (thr == 0) ? $urandom_range(0, 4) : $urandom_range(1, 8);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_MAX_ITER, cap);
      end
      if ($urandom_range(0, 3) != 0 || points_loaded > 40) send_cmd(OP_CLEAR, 0);
      n_pts = $urandom_range(0, 12);
      for (int i = 0; i < n_pts * eff_dim() + $urandom_range(0, 1); i++)
        send_cmd(OP_LOAD, rand_coord());
      if ($urandom_range(0, 4) == 0) send_cmd($urandom_range(5, 7), $urandom, $urandom);
      if (run_is_safe()) send_cmd(OP_RUN, 0);
      read_back($urandom_range(2, 12));
    end
  endtask

  always @(posedge clk_i) begin
    kce_result_t exp_r;
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        $error("result with no command pending");
        fails++;
      end else begin
        exp_r = expected_q.pop_front();
        if (status_o !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, status_o);
          fails++;
        end
        if (cluster_id_o !== exp_r.cluster_id) begin
          $error("cluster_id: expected %0d, got %0d", exp_r.cluster_id, cluster_id_o);
          fails++;
        end
        if (coord_value_o !== exp_r.coord_value) begin
          $error("coord_value: expected %h, got %h", exp_r.coord_value, coord_value_o);
          fails++;
        end
        if (iteration_count_o !== exp_r.iteration_count) begin
          $error("iteration_count: expected %0d, got %0d", exp_r.iteration_count,
                 iteration_count_o);
          fails++;
        end
        if (final_cost_o !== exp_r.final_cost) begin
          $error("final_cost: expected %h, got %h", exp_r.final_cost, final_cost_o);
          fails++;
        end
      end
    end
  end

  initial begin
    #200ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    k_reg = RST_NUM_CLUSTERS;
    dim_reg = RST_DIMENSION;
    thr_reg = RST_THRESHOLD;
    cap_reg = RST_MAX_ITER;
    foreach (pts[i]) begin
      pts[i] = 0;
      pts_wr[i] = 1'b0;
    end
    foreach (cen[i]) begin
      cen[i] = 0;
      cen_wr[i] = 1'b0;
    end
    foreach (asg[i]) begin
      asg[i] = 0;
      asg_wr[i] = 1'b0;
      pnz[i] = 0;
    end
    foreach (cnz[i]) cnz[i] = 0;
    points_loaded = 0;
    coord_pos = 0;
    cost_acc = 0;
    prev_cost = 0;
    iters = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_basic_run();
    test_zero_divisor();
    test_store_full();
    test_register_extremes();
    test_random_runs();
    drain();
    repeat (20) @(posedge clk_i);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
